/* rtl/iqwd_pkg.sv */
// ----------------------------------------------------------------------------
// iqwd_pkg
// Shared types and constants for the group-quantized int8 weight dot product:
// controller/datapath command and status words, sequencer states, bounds.
// ----------------------------------------------------------------------------
package iqwd_pkg;

  // Widths fixed by the item format
  localparam int DOT_W  = 24;   // group dot product register
  localparam int Q_W    = 32;   // scale / bias / group sum operands
  localparam int ACC_W  = 64;   // column accumulator
  localparam int OPND_W = 33;   // shared multiplier operand (signed)
  localparam int PROD_W = 66;   // shared multiplier product
  localparam int SUM_W  = 90;   // exact group term before the fraction shift

  // Low nibble of the code in 4-bit mode
  localparam logic [7:0] CODE4_MASK = 8'h0F;

  // Saturation bounds of the accumulator
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SA    = 7'b0000010,
    ST_BG    = 7'b0000100,
    ST_LO    = 7'b0001000,
    ST_HI    = 7'b0010000,
    ST_ADDHI = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_SA = 2'd0,   // weight_scale * act_scale
    MUL_BG = 2'd1,   // weight_bias * act_group_sum
    MUL_LO = 2'd2,   // low half of scale product * group dot
    MUL_HI = 2'd3    // high half of scale product * group dot
  } mul_sel_t;

  // Update of the exact group term
  typedef enum logic [1:0] {
    SUM_HOLD   = 2'd0,
    SUM_LOAD   = 2'd1,
    SUM_ADD    = 2'd2,
    SUM_ADD_HI = 2'd3
  } sum_op_t;

  typedef struct packed {
    logic     accept;    // a word is taken this cycle
    logic     mul_en;    // capture a new product
    mul_sel_t mul_sel;
    logic     keep_sa;   // save the scale product
    sum_op_t  sum_op;
    logic     acc_upd;   // fold the group term into the accumulator
    logic     load_out;  // fold, emit and clear the column
  } cmd_t;

  typedef struct packed {
    logic item_end;      // offered word closes a group or column
    logic col_end;       // group under work closes the column
    logic out_free;      // output register can take a result
  } sts_t;

endpackage

/* rtl/iqwd_item_if.sv */
// ----------------------------------------------------------------------------
// iqwd_item_if
// Input channel: one activation, one weight code and the group operands.
// ----------------------------------------------------------------------------
interface iqwd_item_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] activation;
  logic        [7:0] weight_code;
  logic signed [31:0] weight_scale;
  logic signed [31:0] weight_bias;
  logic signed [31:0] act_scale;
  logic signed [31:0] act_group_sum;
  logic              last_in_group;
  logic              last_in_column;

  modport source (
    output valid, activation, weight_code, weight_scale, weight_bias,
           act_scale, act_group_sum, last_in_group, last_in_column,
    input  ready
  );

  modport sink (
    input  valid, activation, weight_code, weight_scale, weight_bias,
           act_scale, act_group_sum, last_in_group, last_in_column,
    output ready
  );
endinterface

/* rtl/iqwd_result_if.sv */
// ----------------------------------------------------------------------------
// iqwd_result_if
// Result channel: saturated column sum and its overflow flag.
// ----------------------------------------------------------------------------
interface iqwd_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] column_sum;
  logic               overflow;

  modport source (
    output valid, column_sum, overflow,
    input  ready
  );

  modport sink (
    input  valid, column_sum, overflow,
    output ready
  );
endinterface

/* rtl/iqwd_ctrl.sv */
// ----------------------------------------------------------------------------
// iqwd_ctrl
// Sequencer: takes words, and at a group end steps the shared multiplier
// through the group combine, then folds into the accumulator or emits.
// ----------------------------------------------------------------------------
module iqwd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  iqwd_pkg::sts_t  sts,
  output iqwd_pkg::cmd_t  cmd
);
  import iqwd_pkg::*;

  state_t state;
  state_t state_next;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MUL_SA;
    cmd.sum_op   = SUM_HOLD;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.item_end) begin
          state_next = ST_SA;
        end
      end
      ST_SA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SA;
        state_next  = ST_BG;
      end
      ST_BG: begin
        cmd.keep_sa = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BG;
        state_next  = ST_LO;
      end
      ST_LO: begin
        cmd.sum_op  = SUM_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_next  = ST_HI;
      end
      ST_HI: begin
        cmd.sum_op  = SUM_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_next  = ST_ADDHI;
      end
      ST_ADDHI: begin
        cmd.sum_op = SUM_ADD_HI;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold here while a column result cannot be placed
        if (!sts.col_end) begin
          cmd.acc_upd = 1'b1;
          state_next  = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/iqwd_dp.sv */
// ----------------------------------------------------------------------------
// iqwd_dp
// Datapath: per-word MAC into the group dot product, shared 33x33 multiplier
// for the group combine, saturating Q48.16 accumulator and output register.
// ----------------------------------------------------------------------------
module iqwd_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  iqwd_pkg::cmd_t     cmd,
  output iqwd_pkg::sts_t     sts,
  input  logic signed [7:0]  activation,
  input  logic        [7:0]  weight_code,
  input  logic signed [31:0] weight_scale,
  input  logic signed [31:0] weight_bias,
  input  logic signed [31:0] act_scale,
  input  logic signed [31:0] act_group_sum,
  input  logic               last_in_group,
  input  logic               last_in_column,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               result_ready,
  output logic               result_valid,
  output logic signed [63:0] column_sum,
  output logic               overflow
);
  import iqwd_pkg::*;

  logic                     weight_bits;
  logic        [7:0]        code_eff;
  logic signed [16:0]       mac_prod;
  logic        [DOT_W-1:0]  dot_sum;
  logic        [DOT_W-1:0]  group_dot;

  logic        [DOT_W-1:0]  dot_op;
  logic        [Q_W-1:0]    ws_op;
  logic        [Q_W-1:0]    wb_op;
  logic        [Q_W-1:0]    as_op;
  logic        [Q_W-1:0]    ags_op;
  logic                     col_end_q;

  logic signed [OPND_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic        [63:0]       sa_prod;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [SUM_W:0]    total;
  logic                     ovf;
  logic        [ACC_W-1:0]  acc_new;
  logic        [ACC_W-1:0]  column_acc;
  logic                     sat_flag;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_bits <= 1'b0;
    end else if (cfg_we) begin
      weight_bits <= cfg_wdata;
    end
  end

  // Exact product of one word, wrapped into the group dot product
  assign code_eff = weight_bits ? weight_code : (weight_code & CODE4_MASK);
  assign mac_prod = activation * $signed({1'b0, code_eff});
  assign dot_sum  = group_dot + {{(DOT_W-17){mac_prod[16]}}, mac_prod};

  // Accumulate, or close the group and latch its operands
  always_ff @(posedge clk) begin
    if (rst) begin
      group_dot <= '0;
    end else if (cmd.accept) begin
      group_dot <= (last_in_group || last_in_column) ? '0 : dot_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (last_in_group || last_in_column)) begin
      dot_op    <= dot_sum;
      ws_op     <= weight_scale;
      wb_op     <= weight_bias;
      as_op     <= act_scale;
      ags_op    <= act_group_sum;
      col_end_q <= last_in_column;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SA: begin
        mul_a = {ws_op[Q_W-1], ws_op};
        mul_b = {as_op[Q_W-1], as_op};
      end
      MUL_BG: begin
        mul_a = {wb_op[Q_W-1], wb_op};
        mul_b = {ags_op[Q_W-1], ags_op};
      end
      MUL_LO: begin
        mul_a = {1'b0, sa_prod[31:0]};
        mul_b = {{(OPND_W-DOT_W){dot_op[DOT_W-1]}}, dot_op};
      end
      MUL_HI: begin
        mul_a = {sa_prod[63], sa_prod[63:32]};
        mul_b = {{(OPND_W-DOT_W){dot_op[DOT_W-1]}}, dot_op};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.keep_sa) begin
      sa_prod <= prod[63:0];
    end
  end

  // Build the exact group term from the partial products
  assign prod_ext = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    case (cmd.sum_op)
      SUM_LOAD:   sum <= prod_ext;
      SUM_ADD:    sum <= sum + prod_ext;
      SUM_ADD_HI: sum <= sum + (prod_ext <<< 32);
      default:    sum <= sum;
    endcase
  end

  // Floor the fraction, add to the accumulator, saturate
  assign shifted = sum >>> FRAC_BITS;
  assign total   = {shifted[SUM_W-1], shifted}
                 + {{(SUM_W+1-ACC_W){column_acc[ACC_W-1]}}, column_acc};
  assign ovf     = total[SUM_W:ACC_W-1] != {(SUM_W+2-ACC_W){total[ACC_W-1]}};
  assign acc_new = ovf ? (total[SUM_W] ? ACC_MIN : ACC_MAX) : total[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_acc <= '0;
      sat_flag   <= 1'b0;
    end else if (cmd.load_out) begin
      column_acc <= '0;
      sat_flag   <= 1'b0;
    end else if (cmd.acc_upd) begin
      column_acc <= acc_new;
      sat_flag   <= sat_flag | ovf;
    end
  end

  // Output register: hold until the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      column_sum <= acc_new;
      overflow   <= sat_flag | ovf;
    end
  end

  // Status toward the sequencer
  assign sts.item_end = last_in_group || last_in_column;
  assign sts.col_end  = col_end_q;
  assign sts.out_free = !result_valid || result_ready;

endmodule

/* rtl/int8_quant_weight_dot_top.sv */
// ----------------------------------------------------------------------------
// int8_quant_weight_dot_top
// Group-quantized int8 weight dot product for one output column.
//
// Channels: "item" takes one activation and one weight code per word, with
// the group operands (sampled only on a word that closes a group) and the
// group/column end marks; "result" gives one column_sum and overflow per
// column. cfg_we/cfg_wdata write weight_bits (0: 4-bit codes, 1: 8-bit).
// Intake: words that do not close a group are taken back to back; a word that
// closes a group or column stops intake while the group combine runs four
// products through one shared 33x33 multiplier, then a 90-bit add and
// saturate into the accumulator. The column result is loaded into the output
// register from state FIN, which waits until that register is free.
// Receiver stall: a finished result waits in the output register while the
// next column's words keep flowing; only the next column end waits for it.
// Reset clears the group dot, accumulator, overflow flag, weight_bits and
// the output valid.
// ----------------------------------------------------------------------------
module int8_quant_weight_dot_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  iqwd_item_if.sink     item,
  iqwd_result_if.source result,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import iqwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  iqwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and storage
  iqwd_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .activation     (item.activation),
    .weight_code    (item.weight_code),
    .weight_scale   (item.weight_scale),
    .weight_bias    (item.weight_bias),
    .act_scale      (item.act_scale),
    .act_group_sum  (item.act_group_sum),
    .last_in_group  (item.last_in_group),
    .last_in_column (item.last_in_column),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .result_ready   (result.ready),
    .result_valid   (result.valid),
    .column_sum     (result.column_sum),
    .overflow       (result.overflow)
  );

`ifndef SYNTHESIS
  // A result is placed only where the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result loaded over a pending word");

  // A word that closes a group stops intake for the combine
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && sts.item_end) |=> !item.ready)
    else $error("intake open during group combine");

  // A loaded result shows up on the channel
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("loaded result not presented");
`endif

endmodule
